### hdl/extended_gcd_bezout_macros.svh
// Assertion macros shared by the extended gcd block.
`ifndef EXTENDED_GCD_BEZOUT_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EGCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/egcd_pkg.sv
// Package with the types and constants of the extended gcd block.
package egcd_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load;
        logic div_step;
        logic update;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rb_zero;
        logic div_last;
    } t_sts;

endpackage

### hdl/egcd_in_if.sv
// Operand channel: a valid/ready word carrying the two operands.
interface egcd_in_if #(
    parameter int unsigned OPW = egcd_pkg::OPERAND_WIDTH_DEF
);
    logic           valid;
    logic           ready;
    logic [OPW-1:0] a_value;
    logic [OPW-1:0] b_value;

    modport source (output valid, a_value, b_value, input ready);
    modport sink   (input valid, a_value, b_value, output ready);
endinterface

### hdl/egcd_out_if.sv
// Result channel: a valid/ready word carrying the gcd and both coefficients.
interface egcd_out_if #(
    parameter int unsigned OPW = egcd_pkg::OPERAND_WIDTH_DEF
);
    logic               valid;
    logic               ready;
    logic signed [OPW:0] coeff_x;
    logic signed [OPW:0] coeff_y;
    logic [OPW-1:0]      divisor;

    modport source (output valid, coeff_x, coeff_y, divisor, input ready);
    modport sink   (input valid, coeff_x, coeff_y, divisor, output ready);
endinterface

### hdl/egcd_ctrl.sv
// Controller state machine that sequences the Euclid iterations.
module egcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  egcd_pkg::t_sts   i_sts,
    output egcd_pkg::t_cmd   o_cmd,
    output logic             o_out_valid
);

    egcd_pkg::t_state r_state;
    egcd_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= egcd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            egcd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = egcd_pkg::S_CHECK;
            end
            egcd_pkg::S_CHECK: begin
                n_state = i_sts.rb_zero ? egcd_pkg::S_FINISH : egcd_pkg::S_DIV;
            end
            egcd_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = egcd_pkg::S_UPDATE;
            end
            egcd_pkg::S_UPDATE: begin
                n_state = egcd_pkg::S_CHECK;
            end
            egcd_pkg::S_FINISH: begin
                if (w_slot_free) n_state = egcd_pkg::S_IDLE;
            end
            default: n_state = egcd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            egcd_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            egcd_pkg::S_CHECK: begin
            end
            egcd_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            egcd_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            egcd_pkg::S_FINISH: begin
                o_cmd.load_out = w_slot_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // The output word stays valid until the receiver takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hdl/egcd_dpath.sv
// Datapath: bit-serial divider, coefficient accumulators and result register.
module egcd_dpath #(
    parameter int unsigned OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  egcd_pkg::t_cmd           i_cmd,
    output egcd_pkg::t_sts           o_sts,
    output logic [OPERAND_WIDTH:0]   o_x,
    output logic [OPERAND_WIDTH:0]   o_y,
    output logic [OPERAND_WIDTH-1:0] o_g
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_ra, r_rb, r_dvd, r_rem;
    logic [W:0]    r_cx, r_cxn, r_cy, r_cyn;
    logic [W:0]    r_accx, r_accy;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_out_x, r_out_y;
    logic [W-1:0]  r_out_g;

    logic [W:0]    w_rem_sh;
    logic [W:0]    w_rb_ext;
    logic [W:0]    w_diff;
    logic          w_qbit;

    // One restoring division step per cycle; the quotient bit arrives MSB
    // first, so q*cn builds up by doubling and adding.
    assign w_rem_sh = {r_rem, r_dvd[W-1]};
    assign w_rb_ext = {1'b0, r_rb};
    assign w_diff   = w_rem_sh - w_rb_ext;
    assign w_qbit   = (w_rem_sh >= w_rb_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ra   <= i_a;
            r_rb   <= i_b;
            r_cx   <= (W+1)'(1);
            r_cxn  <= '0;
            r_cy   <= '0;
            r_cyn  <= (W+1)'(1);
            r_dvd  <= i_a;
            r_rem  <= '0;
            r_accx <= '0;
            r_accy <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[W-2:0], 1'b0};
            r_rem  <= w_qbit ? w_diff[W-1:0] : w_rem_sh[W-1:0];
            r_accx <= {r_accx[W-1:0], 1'b0} + (w_qbit ? r_cxn : '0);
            r_accy <= {r_accy[W-1:0], 1'b0} + (w_qbit ? r_cyn : '0);
            r_cnt  <= r_cnt + CW'(1);
        end else if (i_cmd.update) begin
            r_ra   <= r_rb;
            r_rb   <= r_rem;
            r_cx   <= r_cxn;
            r_cxn  <= r_cx - r_accx;
            r_cy   <= r_cyn;
            r_cyn  <= r_cy - r_accy;
            r_dvd  <= r_rb;
            r_rem  <= '0;
            r_accx <= '0;
            r_accy <= '0;
            r_cnt  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x <= r_cx;
            r_out_y <= r_cy;
            r_out_g <= r_ra;
        end
    end

    assign o_sts.rb_zero  = (r_rb == '0);
    assign o_sts.div_last = (r_cnt == CW'(W-1));
    assign o_x = r_out_x;
    assign o_y = r_out_y;
    assign o_g = r_out_g;

endmodule

### hdl/extended_gcd_bezout.sv
// Extended gcd block: gcd of two operands with Bezout coefficients x and y.
//
// Usage: the operand channel i_opnd carries a_value and b_value; a word is
// taken when valid and ready are both high. The result channel o_res carries
// divisor, coeff_x and coeff_y with a*x + b*y = divisor; b zero gives
// divisor a, x 1, y 0.
// Flow: one word is in work at a time. After the operand word is taken,
// each Euclid iteration runs one check state, one restoring divide step per
// quotient bit in the bit-serial divider, and one update state. After k
// iterations the result is loaded; ready rises again at that same edge.
// k reaches about 45 for 31-bit operands and is 0 when b is zero.
// The result sits in an output register, so the next operand word is taken
// while an earlier result still waits. If the receiver stalls, a finished
// result holds in the last state until the output register frees up.
// Reset is synchronous and active low; it clears the controller and the
// output valid flag. No state is kept between words.
`include "extended_gcd_bezout_macros.svh"

module extended_gcd_bezout #(
    parameter int unsigned OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    egcd_in_if.sink     i_opnd,
    egcd_out_if.source  o_res
);

    egcd_pkg::t_cmd w_cmd;
    egcd_pkg::t_sts w_sts;
    logic           w_out_valid;

    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_opnd.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_out_valid (w_out_valid)
    );

    egcd_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .i_clk (i_clk),
        .i_a   (i_opnd.a_value),
        .i_b   (i_opnd.b_value),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_x   (o_res.coeff_x),
        .o_y   (o_res.coeff_y),
        .o_g   (o_res.divisor)
    );

    assign i_opnd.ready = w_cmd.in_ready;
    assign o_res.valid  = w_out_valid;

    `EGCD_ASSERT_SAME(a_out_slot_free, i_clk, i_rst_n, w_cmd.load_out,
        (!o_res.valid || o_res.ready), "result loaded over a waiting word")
    `EGCD_ASSERT_SAME(a_done_on_zero, i_clk, i_rst_n, w_cmd.load_out,
        w_sts.rb_zero, "result loaded before remainder reached zero")
    `EGCD_ASSERT_SAME(a_step_nonzero, i_clk, i_rst_n, w_cmd.div_step,
        !w_sts.rb_zero, "divide step with zero divisor")
    `EGCD_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, (i_opnd.valid && i_opnd.ready),
        !i_opnd.ready, "operand taken while busy")

endmodule

### test/extended_gcd_bezout_test.sv
// Self-checking testbench for the extended gcd block with Bezout coefficients.
module extended_gcd_bezout_test;

    localparam int unsigned OPW = egcd_pkg::OPERAND_WIDTH_DEF;
    localparam logic [OPW-1:0] MAX_OPND = {OPW{1'b1}};
    // Allow several times the length of the longest Euclid run.
    localparam int unsigned QUIET_LIMIT = 8000;
    localparam int unsigned TAIL_CYCLES = 2 * (OPW + 2);

    typedef struct packed {
        logic signed [OPW:0] coeff_x;
        logic signed [OPW:0] coeff_y;
        logic [OPW-1:0]      divisor;
    } t_bezout;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    egcd_in_if  #(.OPW(OPW)) opnd_if ();
    egcd_out_if #(.OPW(OPW)) res_if ();

    extended_gcd_bezout #(.OPERAND_WIDTH(OPW)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_opnd  (opnd_if),
        .o_res   (res_if)
    );

    t_bezout pending[$];
    bit      steady = 1'b0;
    int      errors = 0;
    int      words_taken = 0;
    int      results_checked = 0;
    int      a_zero_words = 0;
    int      b_zero_words = 0;
    int      longest_run = 0;
    int      quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    // Iterative extended Euclid; coefficients wrap at 64 bits and are cut to the field width.
    function automatic t_bezout bezout_of(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                                          output int steps);
        logic [63:0] r0, r1, x0, x1, y0, y1, q, t;
        t_bezout res;
        r0 = 64'(a);
        r1 = 64'(b);
        x0 = 64'd1;
        x1 = 64'd0;
        y0 = 64'd0;
        y1 = 64'd1;
        steps = 0;
        while (r1 != 64'd0) begin
            q = r0 / r1;
            t = r1;
            r1 = r0 % r1;
            r0 = t;
            t = x1;
            x1 = x0 - q * x1;
            x0 = t;
            t = y1;
            y1 = y0 - q * y1;
            y0 = t;
            steps++;
        end
        res.coeff_x = x0[OPW:0];
        res.coeff_y = y0[OPW:0];
        res.divisor = r0[OPW-1:0];
        return res;
    endfunction

    // Predicts each accepted operand word and checks each accepted result word.
    always @(posedge i_clk) begin
        t_bezout want;
        int steps;
        if (i_rst_n) begin
            quiet_cycles++;
            if (res_if.valid && res_if.ready) begin
                quiet_cycles = 0;
                if (pending.size() == 0) begin
                    $error("unexpected result: divisor %0d, coeff_x %0d, coeff_y %0d",
                           res_if.divisor, res_if.coeff_x, res_if.coeff_y);
                    errors++;
                end else begin
                    want = pending.pop_front();
                    results_checked++;
                    if (res_if.coeff_x !== want.coeff_x) begin
                        $error("coeff_x: expected %0d, got %0d", want.coeff_x, res_if.coeff_x);
                        errors++;
                    end
                    if (res_if.coeff_y !== want.coeff_y) begin
                        $error("coeff_y: expected %0d, got %0d", want.coeff_y, res_if.coeff_y);
                        errors++;
                    end
                    if (res_if.divisor !== want.divisor) begin
                        $error("divisor: expected %0d, got %0d", want.divisor, res_if.divisor);
                        errors++;
                    end
                end
            end
            if (opnd_if.valid && opnd_if.ready) begin
                quiet_cycles = 0;
                pending.push_back(bezout_of(opnd_if.a_value, opnd_if.b_value, steps));
                words_taken++;
                if (opnd_if.a_value == '0) a_zero_words++;
                if (opnd_if.b_value == '0) b_zero_words++;
                if (steps > longest_run) longest_run = steps;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, long ready stretches, none in steady mode.
    initial begin
        int n;
        bit level;
        res_if.ready = 1'b0;
        forever begin
            if (steady) begin
                @(negedge i_clk);
                res_if.ready = 1'b1;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    level = 1'b0;
                    n = $urandom_range(1, 9);
                end else begin
                    level = 1'b1;
                    n = $urandom_range(1, 40);
                end
                repeat (n) begin
                    @(negedge i_clk);
                    res_if.ready = level;
                end
            end
        end
    end

    // Offers one operand word and returns at the edge where it is taken.
    task automatic send_word(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
        int gap;
        if (!steady && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge i_clk);
                opnd_if.valid = 1'b0;
                opnd_if.a_value = OPW'($urandom);
                opnd_if.b_value = OPW'($urandom);
            end
        end
        @(negedge i_clk);
        opnd_if.valid = 1'b1;
        opnd_if.a_value = a;
        opnd_if.b_value = b;
        do @(posedge i_clk); while (!opnd_if.ready);
    endtask

    task automatic send_both_orders(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
        send_word(a, b);
        send_word(b, a);
    endtask

    task automatic make_pair(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
        logic [OPW-1:0] g;
        case ($urandom_range(0, 9)) inside
            [0:3]: begin
                a = OPW'($urandom);
                b = OPW'($urandom);
            end
            [4:6]: begin
                a = OPW'($urandom) >> $urandom_range(0, OPW - 1);
                b = OPW'($urandom) >> $urandom_range(0, OPW - 1);
            end
            7: begin
                // Shared factor, so the gcd is usually well above one.
                g = OPW'($urandom_range(1, 65535));
                a = OPW'(g * $urandom_range(0, 32767));
                b = OPW'(g * $urandom_range(0, 32767));
            end
            8: begin
                // One operand a multiple of the other.
                g = OPW'($urandom_range(1, 65535));
                a = OPW'(g * $urandom_range(0, 32767));
                b = g;
                if ($urandom_range(0, 1) == 1) begin
                    b = a;
                    a = g;
                end
            end
            default: begin
                a = ($urandom_range(0, 3) == 0) ? '0 : OPW'($urandom_range(1, 50));
                b = ($urandom_range(0, 3) == 0) ? '0 : OPW'($urandom_range(1, 50));
            end
        endcase
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        opnd_if.valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        send_word('0, '0);
        send_word(OPW'(12), '0);
        send_word('0, OPW'(18));
        send_word(OPW'(1), OPW'(1));
        send_word(OPW'(7), OPW'(7));
        send_both_orders(OPW'(12), OPW'(18));
        send_word(OPW'(240), OPW'(46));
        send_word(OPW'(17), OPW'(5));
        send_both_orders(OPW'(100), OPW'(25));
    endtask

    task automatic test_extremes();
        send_word(MAX_OPND, MAX_OPND);
        send_both_orders(MAX_OPND, '0);
        send_both_orders(MAX_OPND, OPW'(1));
        send_both_orders(MAX_OPND, MAX_OPND - OPW'(1));
        // Consecutive Fibonacci numbers give the longest quotient chain.
        send_both_orders(OPW'(1836311903), OPW'(1134903170));
        send_both_orders(OPW'(31'h5555_5555), OPW'(31'h2AAA_AAAA));
        send_word(OPW'(1) << (OPW - 1), OPW'(3));
    endtask

    task automatic test_random_mix(input int count);
        logic [OPW-1:0] a, b;
        repeat (count) begin
            make_pair(a, b);
            send_word(a, b);
        end
    endtask

    // The sender holds off until the block has delivered everything.
    task automatic test_pause_for_results();
        logic [OPW-1:0] a, b;
        repeat (5) begin
            repeat (8) begin
                make_pair(a, b);
                send_word(a, b);
            end
            drop_valid();
            wait_for_results();
        end
    endtask

    task automatic test_steady_stream(input int count);
        steady = 1'b1;
        test_random_mix(count);
    endtask

    initial begin
        opnd_if.valid = 1'b0;
        opnd_if.a_value = '0;
        opnd_if.b_value = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_special_cases();
        test_extremes();
        test_random_mix(1480);
        test_pause_for_results();
        test_steady_stream(160);

        drop_valid();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending.size() != 0) begin
            $error("%0d results never arrived", pending.size());
            errors++;
        end

        $display("Checked %0d gcd results from %0d operand words; longest run %0d Euclid steps.",
                 results_checked, words_taken, longest_run);
        $display("Words with a zero: %0d, with b zero: %0d; mismatches: %0d.",
                 a_zero_words, b_zero_words, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/egcd_pkg.sv
hdl/egcd_in_if.sv
hdl/egcd_out_if.sv
hdl/egcd_ctrl.sv
hdl/egcd_dpath.sv
hdl/extended_gcd_bezout.sv
test/extended_gcd_bezout_test.sv
